### hdl/multiplexed_segment_display_scanner_defines.svh
// Assertion macros shared by the segment display scanner RTL.
// Used by the queue and back-end modules; needs clk and arst_n in scope.
`ifndef MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_DEFINES_SVH
`define MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MSDS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/msds_pkg.sv
// Package for the segment display scanner: constants, types, glyph table
// and board bit order. No dependencies.
package msds_pkg;

	localparam int DIGIT_COUNT_DEF = 6;
	localparam int DIGIT_W = 3;
	localparam int POS_W = 3;
	localparam int CHAR_W = 8;
	localparam int TIME_W = 32;
	localparam int SEC_W = 6;
	localparam int COT_W = 16;
	localparam int WORD_W = 16;
	localparam int CNT_W = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COT_W-1:0] COLON_ON_TIME_RESET = 16'd500;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [WORD_W-1:0] STAR_WORD = 16'h03FC;
	localparam logic [CNT_W-1:0] LATCH_SLOT = 5'd16;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// One queued refresh: the board-order word and the digit enables.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [DIGIT_W-1:0] digit_off;
		logic [DIGIT_W-1:0] digit_on;
	} entry_t;

	// Queue status seen by the front end and the back end.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Character code to segment word, A..N in bits 15..2.
	function automatic logic [WORD_W-1:0] glyph(input logic [CHAR_W-1:0] code);
		logic [CHAR_W-1:0] c;
		logic [WORD_W-1:0] w;
		c = (code inside {[8'h61:8'h7A]}) ? code - 8'd32 : code;
		case (c)
			8'h30, 8'h4F: w = 16'hFC00; // '0', 'O'
			8'h31: w = 16'h6000;
			8'h32: w = 16'hDB00;
			8'h33: w = 16'hF300;
			8'h34: w = 16'h6700;
			8'h35, 8'h53: w = 16'hB700; // '5', 'S'
			8'h36: w = 16'hBF00;
			8'h37: w = 16'hE000;
			8'h38: w = 16'hFF00;
			8'h39: w = 16'hF700;
			8'h41: w = 16'hEF00;
			8'h42, 8'h44: w = 16'hF148; // 'D' reuses the 'B' pattern
			8'h43: w = 16'h9C00;
			8'h45: w = 16'h9F00;
			8'h46: w = 16'h8F00;
			8'h47: w = 16'hBD00;
			8'h48: w = 16'h6F00;
			8'h49: w = 16'h9048;
			8'h4A: w = 16'h7800;
			8'h4B: w = 16'h0E24;
			8'h4C: w = 16'h1C00;
			8'h4D: w = 16'h6CA0;
			8'h4E: w = 16'h6C84;
			8'h50: w = 16'hCF00;
			8'h51: w = 16'hFC04;
			8'h52: w = 16'hCF04;
			8'h54: w = 16'h8048;
			8'h55: w = 16'h7C00;
			8'h56: w = 16'h0C30;
			8'h57: w = 16'h6C14;
			8'h58: w = 16'h00B4;
			8'h59: w = 16'h00A8;
			8'h5A: w = 16'h9030;
			8'h2B: w = 16'h0348; // '+'
			8'h2D: w = 16'h0300; // '-'
			8'h2F: w = 16'h0030; // '/'
			8'h5C: w = 16'h0084; // backslash
			8'h20: w = 16'h0000; // space
			8'h2C, 8'h2E: w = 16'h0010; // comma, period
			8'h01: w = 16'h8000;
			8'h02: w = 16'h4000;
			8'h03: w = 16'h2000;
			8'h04: w = 16'h1000;
			8'h05: w = 16'h0800;
			8'h06: w = 16'h0400;
			default: w = STAR_WORD;
		endcase
		return w;
	endfunction

	// Segment word to board order; the colon bit (bit 0) is left clear.
	function automatic logic [WORD_W-1:0] to_board(input logic [WORD_W-1:0] w);
		return {w[15], w[10], w[14], w[5], w[6], w[7], w[9], 1'b0,
			w[8], w[4], w[3], w[2], w[13], w[11], w[12], 1'b0};
	endfunction

endpackage

### hdl/msds_if.sv
// Stream interfaces for the segment display scanner: request and result.
// Depends on msds_pkg.
interface msds_cmd_if;
	import msds_pkg::*;
	logic valid;
	logic ready;
	logic kind;
	logic [POS_W-1:0] position;
	logic [CHAR_W-1:0] character;
	logic [TIME_W-1:0] now_ms;
	logic [SEC_W-1:0] seconds_value;
	logic time_mode;
	modport source(output valid, kind, position, character, now_ms, seconds_value,
		time_mode, input ready);
	modport sink(input valid, kind, position, character, now_ms, seconds_value,
		time_mode, output ready);
endinterface

interface msds_res_if;
	import msds_pkg::*;
	logic valid;
	logic ready;
	logic serial_bit;
	logic is_latch;
	logic [DIGIT_W-1:0] digit_off;
	logic [DIGIT_W-1:0] digit_on;
	logic last;
	modport source(output valid, serial_bit, is_latch, digit_off, digit_on, last,
		input ready);
	modport sink(input valid, serial_bit, is_latch, digit_off, digit_on, last,
		output ready);
endinterface

### hdl/msds_front.sv
// Front end: accepts requests, holds the character buffer, scan index and
// colon timing, and turns each tick into a queue entry. Depends on msds_pkg.
module msds_front #(
	parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	msds_cmd_if.sink cmd,
	input logic cfg_we,
	input logic [msds_pkg::COT_W-1:0] cfg_wdata,
	input msds_pkg::q_stat_t q_stat,
	output logic push,
	output msds_pkg::entry_t push_entry
);
	import msds_pkg::*;

	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

	logic [CHAR_W-1:0] buf_q [DIGIT_COUNT];
	logic [IDX_W-1:0] scan_q;
	logic [SEC_W-1:0] last_sec_q;
	logic [TIME_W-1:0] last_change_q;
	logic [COT_W-1:0] colon_time_q;

	logic accept;
	logic sec_changed;
	logic [TIME_W-1:0] since;
	logic colon;
	logic [IDX_W-1:0] scan_prev;
	logic [IDX_W-1:0] scan_next;
	logic pos_ok;

	assign cmd.ready = !q_stat.full;
	assign accept = cmd.valid && cmd.ready;
	assign pos_ok = ({1'b0, cmd.position} < 4'(DIGIT_COUNT));

	// A seconds change restarts the colon window at this very tick.
	assign sec_changed = (cmd.seconds_value != last_sec_q);
	assign since = cmd.now_ms - (sec_changed ? cmd.now_ms : last_change_q);
	assign colon = cmd.time_mode && (since < {16'b0, colon_time_q});

	assign scan_prev = (scan_q == '0) ? IDX_LAST : scan_q - 1'b1;
	assign scan_next = (scan_q == IDX_LAST) ? '0 : scan_q + 1'b1;

	assign push = accept && (cmd.kind == KIND_TICK);
	assign push_entry.word = to_board(glyph(buf_q[scan_q])) | {15'b0, colon};
	assign push_entry.digit_off = DIGIT_W'(scan_prev);
	assign push_entry.digit_on = DIGIT_W'(scan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				buf_q[i] <= CHAR_ZERO;
			end
			scan_q <= '0;
			last_sec_q <= '0;
			last_change_q <= '0;
			colon_time_q <= COLON_ON_TIME_RESET;
		end else begin
			if (cfg_we) begin
				colon_time_q <= cfg_wdata;
			end
			if (accept && (cmd.kind == KIND_WRITE) && pos_ok) begin
				buf_q[cmd.position[IDX_W-1:0]] <= cmd.character;
			end
			if (push) begin
				scan_q <= scan_next;
				if (sec_changed) begin
					last_sec_q <= cmd.seconds_value;
					last_change_q <= cmd.now_ms;
				end
			end
		end
	end

endmodule

### hdl/msds_queue.sv
// Short queue of refresh entries between the front and back ends.
// Depends on msds_pkg and the assertion macro header.
module msds_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input msds_pkg::entry_t push_entry,
	input logic pop,
	output msds_pkg::entry_t head,
	output msds_pkg::q_stat_t q_stat
);
	import msds_pkg::*;
	`include "multiplexed_segment_display_scanner_defines.svh"

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_QW-1:0] fill_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head = mem_q[rd_q];
	assign q_stat.full = (fill_q == CNT_QW'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	`MSDS_ASSERT_IMPL(a_no_overflow, push, !q_stat.full, "queue push while full")
	`MSDS_ASSERT_IMPL(a_no_underflow, pop, !q_stat.empty, "queue pop while empty")
	`MSDS_ASSERT_NEXT(a_fill_grows, push && !pop, !q_stat.empty, "entry lost after push")

endmodule

### hdl/msds_back.sv
// Back end: serializes the head queue entry into sixteen bit results and one
// latch result through an output register. Depends on msds_pkg and the macros.
module msds_back (
	input logic clk,
	input logic arst_n,
	input msds_pkg::entry_t head,
	input msds_pkg::q_stat_t q_stat,
	output logic pop,
	msds_res_if.source res
);
	import msds_pkg::*;
	`include "multiplexed_segment_display_scanner_defines.svh"

	logic [CNT_W-1:0] slot_q;
	logic valid_q;
	logic bit_q;
	logic latch_q;
	logic [DIGIT_W-1:0] off_q;
	logic [DIGIT_W-1:0] on_q;

	logic advance;
	logic load;
	logic at_latch;

	assign advance = !valid_q || res.ready;
	assign load = advance && !q_stat.empty;
	assign at_latch = (slot_q == LATCH_SLOT);
	assign pop = load && at_latch;

	assign res.valid = valid_q;
	assign res.serial_bit = bit_q;
	assign res.is_latch = latch_q;
	assign res.last = latch_q;
	assign res.digit_off = off_q;
	assign res.digit_on = on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			slot_q <= at_latch ? '0 : slot_q + 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	// Payload only; the latch slot carries the digit enables, bit slots zeros.
	always_ff @(posedge clk) begin
		if (load) begin
			latch_q <= at_latch;
			bit_q <= at_latch ? 1'b0 : head.word[4'(15 - int'(slot_q[3:0]))];
			off_q <= at_latch ? head.digit_off : '0;
			on_q <= at_latch ? head.digit_on : '0;
		end
	end

	`MSDS_ASSERT_IMPL(a_slot_range, 1'b1, slot_q <= LATCH_SLOT, "slot counter out of range")
	`MSDS_ASSERT_IMPL(a_latch_clean, valid_q && latch_q, !bit_q, "latch result carries data")
	`MSDS_ASSERT_NEXT(a_hold, valid_q && !res.ready, valid_q && $stable(slot_q),
		"stalled result moved")

endmodule

### hdl/multiplexed_segment_display_scanner.sv
// Multiplexed 14-segment display scanner, top level.
// A tick's first bit result passes through the queue and the back-end output register.
// A tick makes sixteen bit results and a latch result in the back-end serializer;
// write requests are taken while the queue is not full, and the queue holds two ticks.
// Reset (arst_n low): buffer all '0', scan index, seconds and window cleared,
// colon_on_time 500 ms, queue and output empty.
module multiplexed_segment_display_scanner #(
	parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	msds_cmd_if.sink cmd,
	msds_res_if.source res,
	input logic cfg_we,
	input logic [msds_pkg::COT_W-1:0] cfg_wdata
);
	import msds_pkg::*;

	// The front end decides everything a tick shows at the moment the request
	// is accepted: the glyph at the scan index, the colon window, and the
	// digit enables. That snapshot goes into a short queue, so later writes to
	// the buffer cannot disturb a refresh that is still being shifted out.
	logic push;
	entry_t push_entry;
	logic pop;
	entry_t head;
	q_stat_t q_stat;

	msds_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_stat(q_stat),
		.push(push),
		.push_entry(push_entry)
	);

	// Two entries let the front end take the next tick while the back end is
	// still shifting the previous one.
	msds_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.q_stat(q_stat)
	);

	// The back end walks sixteen bit slots, most significant first, then the
	// latch slot, and pops the entry when the latch result is loaded.
	msds_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_stat(q_stat),
		.pop(pop),
		.res(res)
	);

endmodule

### verif/msds_segment_checker.sv
`timescale 1ns / 100ps
// Checker for the segment display scanner: follows the request and result
// streams, predicts every result and compares it field by field.
// Depends on msds_pkg and the msds_cmd_if / msds_res_if interfaces.
module msds_segment_checker (
	input logic clk,
	input logic arst_n,
	msds_cmd_if cmd,
	msds_res_if res,
	input logic cfg_we,
	input logic [msds_pkg::COT_W-1:0] cfg_wdata,
	output int mismatches,
	output int outstanding
);
	import msds_pkg::*;

	localparam int DIGITS = DIGIT_COUNT_DEF;

	// Segment letters in the decoded word, A in bit 15 down to N in bit 2.
	localparam int SEG_A = 15, SEG_B = 14, SEG_C = 13, SEG_D = 12, SEG_E = 11;
	localparam int SEG_F = 10, SEG_G = 9, SEG_H = 8, SEG_I = 7, SEG_J = 6;
	localparam int SEG_K = 5, SEG_L = 4, SEG_M = 3, SEG_N = 2;

	typedef struct packed {
		logic serial_bit;
		logic is_latch;
		logic [DIGIT_W-1:0] digit_off;
		logic [DIGIT_W-1:0] digit_on;
		logic last;
	} shift_item_t;

	logic [CHAR_W-1:0] shown_chars [DIGITS];
	logic [DIGIT_W-1:0] scan_pos;
	logic [SEC_W-1:0] seen_seconds;
	logic [TIME_W-1:0] colon_stamp;
	logic [COT_W-1:0] colon_window;
	shift_item_t queued_shift_items[$];

	function automatic logic [WORD_W-1:0] segment_pattern(input logic [CHAR_W-1:0] code);
		logic [CHAR_W-1:0] up;
		up = (code >= "a" && code <= "z") ? code - 8'd32 : code;
		// Control codes 1 to 6 each light one of the outer segments A to F.
		if (up >= 8'd1 && up <= 8'd6)
			return 16'h8000 >> (up - 8'd1);
		case (up)
			"0", "O": return 16'hFC00;
			"1": return 16'h6000;
			"2": return 16'hDB00;
			"3": return 16'hF300;
			"4": return 16'h6700;
			"5", "S": return 16'hB700;
			"6": return 16'hBF00;
			"7": return 16'hE000;
			"8": return 16'hFF00;
			"9": return 16'hF700;
			"A": return 16'hEF00;
			"B", "D": return 16'hF148;
			"C": return 16'h9C00;
			"E": return 16'h9F00;
			"F": return 16'h8F00;
			"G": return 16'hBD00;
			"H": return 16'h6F00;
			"I": return 16'h9048;
			"J": return 16'h7800;
			"K": return 16'h0E24;
			"L": return 16'h1C00;
			"M": return 16'h6CA0;
			"N": return 16'h6C84;
			"P": return 16'hCF00;
			"Q": return 16'hFC04;
			"R": return 16'hCF04;
			"T": return 16'h8048;
			"U": return 16'h7C00;
			"V": return 16'h0C30;
			"W": return 16'h6C14;
			"X": return 16'h00B4;
			"Y": return 16'h00A8;
			"Z": return 16'h9030;
			"+": return 16'h0348;
			"-": return 16'h0300;
			"/": return 16'h0030;
			"\\": return 16'h0084;
			" ": return 16'h0000;
			",", ".": return 16'h0010;
			default: return STAR_WORD;
		endcase
	endfunction

	// Board wiring: A F B K J I G - in the first byte, H L M N C E D colon in the second.
	function automatic logic [WORD_W-1:0] board_order(input logic [WORD_W-1:0] seg);
		return {seg[SEG_A], seg[SEG_F], seg[SEG_B], seg[SEG_K], seg[SEG_J], seg[SEG_I],
			seg[SEG_G], 1'b0, seg[SEG_H], seg[SEG_L], seg[SEG_M], seg[SEG_N], seg[SEG_C],
			seg[SEG_E], seg[SEG_D], 1'b0};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [WORD_W-1:0] word;
		logic [DIGIT_W-1:0] idx;
		shift_item_t want;
		if (!arst_n) begin
			for (int p = 0; p < DIGITS; p++)
				shown_chars[p] = CHAR_ZERO;
			scan_pos = '0;
			seen_seconds = '0;
			colon_stamp = '0;
			colon_window = COLON_ON_TIME_RESET;
			queued_shift_items.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				colon_window = cfg_wdata;
			if (cmd.valid && cmd.ready) begin
				if (cmd.kind == KIND_WRITE) begin
					if (int'(cmd.position) < DIGITS)
						shown_chars[cmd.position] = cmd.character;
				end else begin
					idx = scan_pos;
					word = board_order(segment_pattern(shown_chars[idx]));
					// The seconds stamp moves even when time mode is off.
					if (cmd.seconds_value != seen_seconds) begin
						seen_seconds = cmd.seconds_value;
						colon_stamp = cmd.now_ms;
					end
					word[0] = cmd.time_mode && ((cmd.now_ms - colon_stamp) < {16'd0, colon_window});
					for (int k = WORD_W - 1; k >= 0; k--)
						queued_shift_items.push_back(shift_item_t'{word[k], 1'b0, '0, '0, 1'b0});
					want.serial_bit = 1'b0;
					want.is_latch = 1'b1;
					want.digit_off = (idx == '0) ? DIGIT_W'(DIGITS - 1) : idx - DIGIT_W'(1);
					want.digit_on = idx;
					want.last = 1'b1;
					queued_shift_items.push_back(want);
					scan_pos = (int'(idx) == DIGITS - 1) ? '0 : idx + DIGIT_W'(1);
				end
			end
			if (res.valid && res.ready) begin
				if (queued_shift_items.size() == 0) begin
					report_mismatch("unexpected result, serial_bit", 32'(res.serial_bit), 32'd0);
				end else begin
					want = queued_shift_items.pop_front();
					if (res.serial_bit !== want.serial_bit)
						report_mismatch("serial_bit", 32'(res.serial_bit), 32'(want.serial_bit));
					if (res.is_latch !== want.is_latch)
						report_mismatch("is_latch", 32'(res.is_latch), 32'(want.is_latch));
					if (res.digit_off !== want.digit_off)
						report_mismatch("digit_off", 32'(res.digit_off), 32'(want.digit_off));
					if (res.digit_on !== want.digit_on)
						report_mismatch("digit_on", 32'(res.digit_on), 32'(want.digit_on));
					if (res.last !== want.last)
						report_mismatch("last", 32'(res.last), 32'(want.last));
				end
			end
			outstanding <= queued_shift_items.size();
		end
	end

endmodule

### verif/multiplexed_segment_display_scanner_tb.sv
`timescale 1ns / 100ps
// Testbench top for the segment display scanner: clock, reset, request
// stimulus, result back-pressure, watchdog and the final verdict.
// Depends on msds_pkg, msds_if, the scanner RTL and msds_segment_checker.
module multiplexed_segment_display_scanner_tb;
	import msds_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 5;
	// A write request makes no result, so after the last result the block may
	// still hold one; this wait lets it land.
	localparam int IDLE_SETTLE = 6;
	localparam int END_SETTLE = 24;
	// Longest correct quiet stretch is a receiver stall or a sender gap; this
	// limit is far above either.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_COUNT = 5;
	localparam int PHASE_ITEMS = 32;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_LONG_STALLS
	} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [COT_W-1:0] cfg_wdata;
	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int burst_left = 0;
	logic [TIME_W-1:0] wall_ms = '0;
	logic [SEC_W-1:0] wall_sec = '0;
	logic [COT_W-1:0] colon_settings [PHASE_COUNT];
	ready_mode_t ready_mode = RDY_ALWAYS;
	int mode_left = 0;
	int ready_hold = 0;

	msds_cmd_if cmd_ch();
	msds_res_if res_ch();

	always #HALF_PERIOD clk = ~clk;

	multiplexed_segment_display_scanner i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	msds_segment_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// The result receiver switches at random times between three behaviors:
	// always ready, ready at random with probability 3/4, and alternating
	// stretches of stall and ready of random length.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 2));
			mode_left <= $urandom_range(40, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			RDY_ALWAYS: res_ch.ready <= 1'b1;
			RDY_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (ready_hold == 0) begin
					res_ch.ready <= ~res_ch.ready;
					ready_hold <= $urandom_range(1, 24);
				end else begin
					ready_hold <= ready_hold - 1;
				end
			end
		endcase
	end

	// The watchdog counts cycles in which neither stream moves anything. A
	// hung block shows up here rather than as an endless run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAIL multiplexed_segment_display_scanner");
				$finish;
			end
		end
	end

	// Sends one request and returns at the edge that accepts it. Requests go
	// out in bursts; before each burst there may be a random gap that can be
	// longer than one refresh, so gaps land on every bit slot. Some bursts
	// are long and some gaps are zero, giving stretches with no idling.
	task automatic send_request(input logic kind, input logic [POS_W-1:0] pos,
		input logic [CHAR_W-1:0] ch, input logic [TIME_W-1:0] now,
		input logic [SEC_W-1:0] sec, input logic tmode);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(20, 60))
				: int'($urandom_range(1, 8));
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= kind;
		cmd_ch.position <= pos;
		cmd_ch.character <= ch;
		cmd_ch.now_ms <= now;
		cmd_ch.seconds_value <= sec;
		cmd_ch.time_mode <= tmode;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// A write only uses position and character; the other fields carry noise.
	task automatic write_char(input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch);
		send_request(KIND_WRITE, pos, ch, $urandom(), SEC_W'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)));
	endtask

	// A refresh tick ignores position and character, which get noise too.
	task automatic refresh(input logic [TIME_W-1:0] now, input logic [SEC_W-1:0] sec,
		input logic tmode);
		send_request(KIND_TICK, POS_W'($urandom_range(0, 7)), CHAR_W'($urandom()), now, sec,
			tmode);
	endtask

	// Stops sending and waits until the checker holds no pending result, then
	// lets the block's request latency pass so a trailing write has landed.
	// The outstanding count is registered, hence the first wait.
	task automatic settle_idle();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// The colon register is only written while the block is idle.
	task automatic set_colon_window(input logic [COT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Character codes are drawn mostly from the printable range so that the
	// table entries get hit, with controls, high codes and the 'D' and 'B'
	// lookalikes mixed in.
	function automatic logic [CHAR_W-1:0] pick_character();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return CHAR_W'($urandom_range(8'h20, 8'h7E));
			4: return CHAR_W'($urandom_range(0, 8));
			5: return CHAR_W'($urandom_range(8'h80, 8'hFF));
			6: return CHAR_W'($urandom());
			7: return ($urandom_range(0, 1) != 0) ? "D" : "d";
			default: return CHAR_W'($urandom_range("0", "9"));
		endcase
	endfunction

	// A random request. Most ticks follow a running wall clock whose time
	// moves forward by a few hundred milliseconds and whose seconds advance
	// now and then, so the colon window opens and closes the way it does in
	// use. Occasionally the time jumps far or to any value, and the seconds
	// jump to any six-bit value.
	task automatic random_request();
		int roll;
		if ($urandom_range(0, 99) < 35) begin
			write_char(POS_W'($urandom_range(0, 7)), pick_character());
		end else begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				wall_ms = $urandom();
			else if (roll < 3)
				wall_ms += $urandom_range(0, 70000);
			else
				wall_ms += $urandom_range(1, 400);
			roll = $urandom_range(0, 19);
			if (roll < 6)
				wall_sec = (wall_sec == 6'd59) ? '0 : wall_sec + 6'd1;
			else if (roll == 6)
				wall_sec = SEC_W'($urandom_range(0, 63));
			refresh(wall_ms, wall_sec, $urandom_range(0, 3) != 0);
		end
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_WRITE;
		cmd_ch.position = '0;
		cmd_ch.character = '0;
		cmd_ch.now_ms = '0;
		cmd_ch.seconds_value = '0;
		cmd_ch.time_mode = 1'b0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		colon_settings = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom()), COLON_ON_TIME_RESET};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the colon time left at its reset value.
		// First tick shows the reset buffer with the window open from time 0.
		refresh(32'd0, 6'd0, 1'b1);
		// A lowercase letter, the 'D' lookalike, single-segment control codes,
		// a high code that falls back to the star and the backslash glyph.
		write_char(3'd0, "d");
		write_char(3'd1, "B");
		write_char(3'd2, 8'h01);
		write_char(3'd3, 8'h06);
		write_char(3'd4, 8'hFF);
		write_char(3'd5, "\\");
		// Positions past the last digit must be dropped.
		write_char(3'd6, "A");
		write_char(3'd7, 8'h80);
		// A seconds change at the very top of the time range, then ticks across
		// the wrap: 1 ms in is lit, 499 ms is the last lit value, 500 is dark.
		refresh(32'hFFFF_FFFF, 6'd59, 1'b1);
		refresh(32'h0000_0000, 6'd59, 1'b1);
		refresh(32'd498, 6'd59, 1'b1);
		refresh(32'd499, 6'd59, 1'b1);
		// Seconds outside 0..59 still count, and they move the stamp while time
		// mode is off; the next tick with time mode on sees the window open.
		refresh(32'h1234_5678, 6'd63, 1'b0);
		refresh(32'h1234_5679, 6'd63, 1'b1);
		write_char(3'd0, 8'h7A);
		write_char(3'd3, 8'h00);
		refresh(32'h8000_0000, 6'd0, 1'b1);
		refresh(32'h8000_01F3, 6'd0, 1'b0);
		wall_ms = 32'h8000_0200;
		settle_idle();

		// Random part in phases, one colon time per phase, the extremes among
		// them. Each phase boundary drains the block completely.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			set_colon_window(colon_settings[phase]);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_request();
			settle_idle();
		end

		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("PASS multiplexed_segment_display_scanner");
		else
			$display("FAIL multiplexed_segment_display_scanner");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/msds_pkg.sv
hdl/msds_if.sv
hdl/msds_front.sv
hdl/msds_queue.sv
hdl/msds_back.sv
hdl/multiplexed_segment_display_scanner.sv
verif/msds_segment_checker.sv
verif/multiplexed_segment_display_scanner_tb.sv
